// ----- rtl/sbox_analysis_tables_macros.svh -----
// Assertion macros for the S-box analysis tables block.
// Included by the top level; expects clk and rst_n in scope.
`ifndef SBOX_ANALYSIS_TABLES_MACROS_SVH
`define SBOX_ANALYSIS_TABLES_MACROS_SVH
`ifndef SYNTHESIS
`define SBAT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sbat: same-cycle check failed");
`define SBAT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sbat: next-cycle check failed");
`else
`define SBAT_ASSERT_SAME(label, ante, cons)
`define SBAT_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- rtl/sbat_pkg.sv -----
// Shared types, codes and helpers for the S-box analysis tables block.
// No dependencies; used by every module of the block.
`default_nettype none
package sbat_pkg;

  localparam int IN_BITS_DEF  = 8;
  localparam int OUT_BITS_DEF = 8;
  localparam int Q_DEPTH      = 2;
  localparam int QAW          = $clog2(Q_DEPTH);
  localparam int CNT_W        = 9;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_DIFF  = 2'd1;
  localparam logic [1:0] OP_LIN   = 2'd2;
  localparam logic [1:0] OP_DEP   = 2'd3;

  typedef struct packed {
    logic [3:0] n;
    logic [3:0] m;
  } widths_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] row;
    logic [7:0] col;
    logic       null_q;
  } cmd_t;

  typedef struct packed {
    logic busy;
  } eng_stat_t;

  function automatic logic [3:0] clamp_width(input logic [3:0] w, input logic [3:0] top);
    logic [3:0] r;
    priority if (w == 4'd0) begin
      r = 4'd1;
    end else if (w > top) begin
      r = top;
    end else begin
      r = w;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/sbat_front.sv -----
// Front end: width registers, input acceptance and command classification.
// Depends on sbat_pkg; feeds sbat_cmd_fifo.
`default_nettype none
module sbat_front #(
  parameter int IN_BITS  = sbat_pkg::IN_BITS_DEF,
  parameter int OUT_BITS = sbat_pkg::OUT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [0:0]        cfg_index,
  input  logic [3:0]        cfg_data,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [15:0]       in_tdata,
  input  logic [1:0]        in_tuser,
  input  logic              q_full,
  output logic              q_push,
  output sbat_pkg::cmd_t    q_cmd,
  output sbat_pkg::widths_t widths
);
  import sbat_pkg::*;

  localparam logic [0:0] REG_IN_BITS  = 1'd0;
  localparam logic [0:0] REG_OUT_BITS = 1'd1;

  logic [3:0] in_bits_r;
  logic [3:0] out_bits_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_bits_r  <= 4'd8;
      out_bits_r <= 4'd8;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_IN_BITS:  in_bits_r  <= cfg_data;
        REG_OUT_BITS: out_bits_r <= cfg_data;
      endcase
    end
  end

  assign widths.n = clamp_width(in_bits_r, 4'(IN_BITS));
  assign widths.m = clamp_width(out_bits_r, 4'(OUT_BITS));

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && in_tready;

  always_comb begin
    q_cmd.kind   = in_tuser;
    q_cmd.row    = in_tdata[7:0];
    q_cmd.col    = in_tdata[15:8];
    q_cmd.null_q = (in_tuser == OP_DEP) &&
                   ((in_tdata[7:0] >= {4'd0, widths.n}) ||
                    (in_tdata[15:8] >= {4'd0, widths.m}));
  end

endmodule
`default_nettype wire

// ----- rtl/sbat_cmd_fifo.sv -----
// Short command queue between the front end and the table engine.
// Depends on sbat_pkg for the command type and depth.
`default_nettype none
module sbat_cmd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  sbat_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output sbat_pkg::cmd_t pop_cmd,
  output logic           empty
);
  import sbat_pkg::*;

  cmd_t             slot_r [Q_DEPTH];
  logic [QAW-1:0]   wr_ptr_r;
  logic [QAW-1:0]   rd_ptr_r;
  logic [QAW:0]     cnt_r;

  assign full    = (cnt_r == (QAW+1)'(Q_DEPTH));
  assign empty   = (cnt_r == '0);
  assign pop_cmd = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/sbat_engine.sv -----
// Table engine: S-box memory, walk sequencer, counter and result register.
// Depends on sbat_pkg; takes commands from sbat_cmd_fifo.
`default_nettype none
module sbat_engine #(
  parameter int IN_BITS  = sbat_pkg::IN_BITS_DEF,
  parameter int OUT_BITS = sbat_pkg::OUT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sbat_pkg::widths_t   widths,
  input  logic                q_empty,
  input  sbat_pkg::cmd_t      q_cmd,
  output logic                q_pop,
  output sbat_pkg::eng_stat_t stat,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [15:0]         out_tdata
);
  import sbat_pkg::*;

  localparam int AW    = IN_BITS;
  localparam int DW    = OUT_BITS;
  localparam int DEPTH = 1 << IN_BITS;
  localparam int RW    = (AW > 8) ? AW : 8;
  localparam int CMPW  = (DW > 8) ? DW : 8;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_WALK   = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_RESULT = 2'd3;

  logic [DW-1:0] mem [DEPTH];

  logic [1:0]       state_r, state_nxt;
  logic [AW-1:0]    x_r, x_nxt;
  logic [AW-1:0]    x1_r;
  logic             v1_r, v1_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0] out_count_r, out_count_nxt;
  logic [DW-1:0]    rd0_r, rd1_r;

  logic [1:0]       kind_r;
  logic [AW-1:0]    d_r, amask_r, imask_r;
  logic [DW-1:0]    omask_r, bsel_r;
  logic [CMPW-1:0]  bcmp_r;

  logic             mem_we, load, hit;
  logic [RW-1:0]    row_w;
  logic [CMPW-1:0]  col_w;
  logic [AW-1:0]    row_a, imask;
  logic [DW-1:0]    col_d, omask;
  logic [DW-1:0]    s0, s1, v;

  assign row_w = RW'(q_cmd.row);
  assign col_w = CMPW'(q_cmd.col);
  assign row_a = row_w[AW-1:0];
  assign col_d = col_w[DW-1:0];

  always_comb begin
    for (int i = 0; i < AW; i++) begin
      imask[i] = (4'(i) < widths.n);
    end
    for (int j = 0; j < DW; j++) begin
      omask[j] = (4'(j) < widths.m);
    end
  end

  assign s0 = rd0_r & omask_r;
  assign s1 = rd1_r & omask_r;
  assign v  = s0 ^ s1;

  always_comb begin
    unique case (kind_r)
      OP_WRITE: hit = 1'b0;
      OP_DIFF:  hit = (CMPW'(v) == bcmp_r);
      OP_LIN:   hit = (^(amask_r & x1_r)) ^ (^(bsel_r & s0));
      OP_DEP:   hit = |(v & bsel_r);
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    x_nxt         = x_r;
    v1_nxt        = 1'b0;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_count_nxt = out_count_r;
    q_pop         = 1'b0;
    mem_we        = 1'b0;
    load          = 1'b0;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (v1_r && hit && (cnt_r != CNT_MAX)) begin
      cnt_nxt = cnt_r + 1'b1;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_cmd.kind == OP_WRITE) begin
            mem_we = 1'b1;
          end else begin
            load      = 1'b1;
            cnt_nxt   = '0;
            x_nxt     = '0;
            state_nxt = q_cmd.null_q ? ST_RESULT : ST_WALK;
          end
        end
      end
      ST_WALK: begin
        v1_nxt = 1'b1;
        x_nxt  = x_r + 1'b1;
        if (x_r == imask_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = cnt_r;
          state_nxt     = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[row_a] <= col_d;
    end
    rd0_r <= mem[x_r];
    rd1_r <= mem[x_r ^ d_r];
  end

  always_ff @(posedge clk) begin
    x1_r        <= x_r;
    x_r         <= x_nxt;
    cnt_r       <= cnt_nxt;
    out_count_r <= out_count_nxt;
    if (load) begin
      kind_r  <= q_cmd.kind;
      imask_r <= imask;
      omask_r <= omask;
      amask_r <= row_a;
      bcmp_r  <= col_w;
      unique case (q_cmd.kind)
        OP_WRITE: begin
          d_r    <= '0;
          bsel_r <= col_d;
        end
        OP_DIFF: begin
          d_r    <= row_a & imask;
          bsel_r <= col_d;
        end
        OP_LIN: begin
          d_r    <= '0;
          bsel_r <= col_d;
        end
        OP_DEP: begin
          d_r    <= AW'(1) << q_cmd.row[3:0];
          bsel_r <= DW'(1) << q_cmd.col[3:0];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      v1_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      v1_r        <= v1_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign stat.busy  = (state_r != ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = 16'(out_count_r);

endmodule
`default_nettype wire

// ----- rtl/sbox_analysis_tables.sv -----
// Channel  | Signals                               | Carries
// in       | in_tvalid/in_tready/in_tdata/in_tuser | mode in tuser, row and column select
// out      | out_tvalid/out_tready/out_tdata       | table count of one query
// cfg      | cfg_valid/cfg_ready/cfg_index/cfg_data| input and output width in use
// A query walks over the S-box memory, which reads two entries per cycle, unless it is
// a dependency query with a bit number beyond the widths; a write needs no walk.
// Reset is synchronous and active low and clears control state and the widths to 8.
// A two-entry queue lets the input side take commands while the engine walks.
// A finished count waits in the output register without holding up the next command.
// Top level of the S-box analysis tables block; uses sbat_pkg, the front end,
// the command queue, the table engine and the assertion macro header.
`default_nettype none
`include "sbox_analysis_tables_macros.svh"
module sbox_analysis_tables #(
  parameter int IN_BITS  = sbat_pkg::IN_BITS_DEF,
  parameter int OUT_BITS = sbat_pkg::OUT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [3:0]  cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // row_sel [7:0], col_sel [15:8]
  input  logic [1:0]  in_tuser,   // mode [1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // table_count [8:0], zeros above
);
  import sbat_pkg::*;

  widths_t   widths;
  cmd_t      push_cmd, pop_cmd;
  logic      q_push, q_pop, q_full, q_empty;
  eng_stat_t eng_stat;

  sbat_front #(
    .IN_BITS (IN_BITS),
    .OUT_BITS(OUT_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd),
    .widths   (widths)
  );

  sbat_cmd_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_cmd(push_cmd),
    .full    (q_full),
    .pop     (q_pop),
    .pop_cmd (pop_cmd),
    .empty   (q_empty)
  );

  sbat_engine #(
    .IN_BITS (IN_BITS),
    .OUT_BITS(OUT_BITS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .widths    (widths),
    .q_empty   (q_empty),
    .q_cmd     (pop_cmd),
    .q_pop     (q_pop),
    .stat      (eng_stat),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  `SBAT_ASSERT_SAME(a_pop_not_empty, q_pop, !q_empty)
  `SBAT_ASSERT_NEXT(a_push_fills, q_push && !q_pop, !q_empty)
  `SBAT_ASSERT_SAME(a_pop_when_idle, q_pop, !eng_stat.busy)

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for sbox_analysis_tables: fills the S-box, then runs
// directed and random table queries under several width settings.
// Depends on sbat_pkg for the operation codes and on the RTL of the block.
`timescale 1ns / 1ps
module testbench;
  import sbat_pkg::*;

  localparam logic [0:0] REG_IN_BITS  = 1'b0;
  localparam logic [0:0] REG_OUT_BITS = 1'b1;
  localparam int DRAIN_CYCLES = 300;
  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int PHASE_ITEMS  = 110;

  class table_count_board;
    logic [7:0]  sbox_copy [256];
    int unsigned in_width;
    int unsigned out_width;
    logic [8:0]  counts_due [$];
    int unsigned mismatches;

    function new();
      in_width   = 8;
      out_width  = 8;
      mismatches = 0;
    endfunction

    function void set_width(logic [0:0] idx, logic [3:0] val);
      int unsigned w;
      w = (val == 4'd0) ? 1 : ((val > 4'd8) ? 8 : val);
      if (idx == REG_IN_BITS) begin
        in_width = w;
      end else begin
        out_width = w;
      end
    endfunction

    function logic [7:0] entry(int unsigned idx);
      logic [7:0] omask;
      omask = 8'((1 << out_width) - 1);
      return sbox_copy[idx[7:0]] & omask;
    endfunction

    function logic [8:0] predict_count(logic [1:0] op, logic [7:0] a, logic [7:0] b);
      int unsigned span;
      int unsigned total;
      logic [7:0]  imask;
      logic [7:0]  xb;
      logic [7:0]  v;
      span  = 1 << in_width;
      imask = 8'(span - 1);
      total = 0;
      for (int unsigned i = 0; i < span; i++) begin
        xb = i[7:0];
        case (op)
          OP_DIFF: begin
            if ((entry(i) ^ entry(i ^ (a & imask))) == b) total++;
          end
          OP_LIN: begin
            total += ^((a & xb) ^ (b & entry(i)));
          end
          default: begin
            if (a < in_width && b < out_width) begin
              v = entry(i) ^ entry(i ^ (1 << a));
              total += v[b[2:0]];
            end
          end
        endcase
      end
      if (total > 511) total = 511;
      return total[8:0];
    endfunction

    function void note_command(logic [1:0] op, logic [7:0] row, logic [7:0] col);
      if (op == OP_WRITE) begin
        sbox_copy[row] = col;
      end else begin
        counts_due.push_back(predict_count(op, row, col));
      end
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      mismatches++;
    endtask

    task check_count(logic [8:0] got);
      logic [8:0] want;
      if (counts_due.size() == 0) begin
        report($sformatf("count %0d arrived with none expected", got));
      end else begin
        want = counts_due.pop_front();
        if (got !== want) report($sformatf("table_count %0d, expected %0d", got, want));
      end
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [0:0]  cfg_index;
  logic [3:0]  cfg_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;

  table_count_board board;
  bit          calm;
  int unsigned hold_cycles;
  int unsigned cycles;

  sbox_analysis_tables u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int unsigned idle_draw();
    return calm ? 0 : $urandom_range(0, 9);
  endfunction

  task automatic send_item(input logic [1:0] op, input logic [7:0] row, input logic [7:0] col);
    int unsigned gap;
    gap = idle_draw();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {col, row};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_command(op, row, col);
  endtask

  task automatic write_widths(input logic [3:0] n_val, input logic [3:0] m_val);
    cfg_valid <= 1'b1;
    cfg_index <= REG_IN_BITS;
    cfg_data  <= n_val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.set_width(REG_IN_BITS, n_val);
    cfg_index <= REG_OUT_BITS;
    cfg_data  <= m_val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.set_width(REG_OUT_BITS, m_val);
    cfg_valid <= 1'b0;
  endtask

  // Writes may still sit in the command queue after the last count arrives.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (board.counts_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_item();
    int unsigned pick;
    int unsigned x;
    int unsigned span;
    logic [7:0]  a;
    logic [7:0]  b;
    logic [7:0]  imask;
    pick  = $urandom_range(0, 99);
    a     = 8'($urandom_range(0, 255));
    b     = 8'($urandom_range(0, 255));
    span  = 1 << board.in_width;
    imask = 8'(span - 1);
    if (pick < 25) begin
      send_item(OP_WRITE, a, b);
    end else if (pick < 50) begin
      if ($urandom_range(0, 3) != 0) begin
        x = $urandom_range(0, span - 1);
        b = board.entry(x) ^ board.entry(x ^ (a & imask));
      end
      send_item(OP_DIFF, a, b);
    end else if (pick < 75) begin
      send_item(OP_LIN, a, b);
    end else begin
      if ($urandom_range(0, 4) != 0) begin
        a = 8'($urandom_range(0, board.in_width - 1));
        b = 8'($urandom_range(0, board.out_width - 1));
      end
      send_item(OP_DEP, a, b);
    end
  endtask

  task automatic run_phase(input logic [3:0] n_val, input logic [3:0] m_val,
                           input int unsigned hold);
    settle();
    write_widths(n_val, m_val);
    calm = ($urandom_range(0, 3) == 0);
    hold_cycles = hold;
    repeat (PHASE_ITEMS) random_item();
  endtask

  initial begin
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        out_tready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      if (idle_draw() > 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      board.check_count(out_tdata[8:0]);
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    board       = new();
    calm        = 1'b0;
    hold_cycles = 0;
    rst_n     <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_IN_BITS;
    cfg_data  <= 4'd0;
    in_tvalid <= 1'b0;
    in_tuser  <= OP_WRITE;
    in_tdata  <= 16'd0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Every entry is written before any query reads it.
    for (int i = 0; i < 256; i++) send_item(OP_WRITE, i[7:0], 8'($urandom_range(0, 255)));

    send_item(OP_WRITE, 8'h00, 8'hFF);
    send_item(OP_WRITE, 8'hFF, 8'h00);
    send_item(OP_WRITE, 8'h55, 8'hAA);
    send_item(OP_DIFF, 8'h00, 8'h00);
    send_item(OP_DIFF, 8'hFF, 8'hFF);
    send_item(OP_DIFF, 8'h80, 8'($urandom_range(0, 255)));
    send_item(OP_LIN, 8'h00, 8'h00);
    send_item(OP_LIN, 8'hFF, 8'hFF);
    send_item(OP_LIN, 8'h01, 8'h80);
    send_item(OP_DEP, 8'd0, 8'd0);
    send_item(OP_DEP, 8'd7, 8'd7);
    send_item(OP_DEP, 8'd8, 8'd0);
    send_item(OP_DEP, 8'd0, 8'd8);
    send_item(OP_DEP, 8'hFF, 8'hFF);

    // Narrow widths: output differences and bit numbers beyond the widths give zero.
    settle();
    write_widths(4'd1, 4'd1);
    send_item(OP_DIFF, 8'h01, 8'hFF);
    send_item(OP_DIFF, 8'hFE, 8'h00);
    send_item(OP_DEP, 8'd1, 8'd0);
    send_item(OP_DEP, 8'd0, 8'd1);
    send_item(OP_DEP, 8'd0, 8'd0);
    send_item(OP_LIN, 8'hFF, 8'hFF);
    repeat (PHASE_ITEMS) random_item();

    run_phase(4'd8, 4'd1, 0);
    run_phase(4'd1, 4'd8, 0);
    run_phase(4'd0, 4'd15, 0);
    run_phase(4'd15, 4'd0, 0);
    run_phase(4'd3, 4'd5, 600);
    for (int p = 0; p < 6; p++) begin
      run_phase(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), 0);
    end
    run_phase(4'd8, 4'd8, 0);

    settle();
    if (board.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
